// ===== rtl/i2a_pkg.sv =====
// Shared types, constants and the digit-to-character function for the number formatter.
package i2a_pkg;

  // Format codes carried on in_command
  typedef enum logic [1:0] {
    CMD_SDEC  = 2'd0,
    CMD_UDEC  = 2'd1,
    CMD_HEXLO = 2'd2,
    CMD_HEXUP = 2'd3
  } cmd_t;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned NDIG_W    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DIDX_W    = $clog2(MAX_DIGITS);

  // floor(n * RECIP / 2^35) == n / 10 for every 32-bit n
  localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned        DEC_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;

  // Result of one divide-by-base step
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] quo;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] d8;
    d8 = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d8;
    end else if (upper) begin
      return CHAR_UPA + d8 - 8'd10;
    end else begin
      return CHAR_LOWA + d8 - 8'd10;
    end
  endfunction

endpackage

// ===== rtl/i2a_digit_unit.sv =====
// Shared divide-by-base unit: one quotient and remainder per request.
module i2a_digit_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic                             hex,
  input  logic [i2a_pkg::VALUE_W-1:0]      mag,
  output i2a_pkg::div_res_t                res
);

  localparam int unsigned PROD_W = 2 * i2a_pkg::VALUE_W;

  logic                         vld_r;
  logic                         hex_r;
  logic [i2a_pkg::VALUE_W-1:0]  mag_r;
  logic [PROD_W-1:0]            prod_r;
  logic [i2a_pkg::VALUE_W-1:0]  quo;
  logic [i2a_pkg::VALUE_W-1:0]  rem_full;

  // Multiplier stage, registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= go;
    end
    hex_r  <= hex;
    mag_r  <= mag;
    prod_r <= PROD_W'(mag) * PROD_W'(i2a_pkg::DEC_RECIP);
  end

  // Correction: decimal remainder = n - 10q via shifts; hex is a shift and a mask
  always_comb begin
    if (hex_r) begin
      quo      = mag_r >> i2a_pkg::DIGIT_W;
      rem_full = {{(i2a_pkg::VALUE_W-i2a_pkg::DIGIT_W){1'b0}}, mag_r[i2a_pkg::DIGIT_W-1:0]};
    end else begin
      quo      = i2a_pkg::VALUE_W'(prod_r >> i2a_pkg::DEC_SHIFT);
      rem_full = mag_r - ((quo << 3) + (quo << 1));
    end
    res.vld = vld_r;
    res.quo = quo;
    res.rem = rem_full[i2a_pkg::DIGIT_W-1:0];
  end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level of the number formatter: command port, digit sequencer, digit store and output.
//
// Usage
//   Present in_command and in_value with start high while busy is low; that edge
//   takes the beat. busy stays high until the last character has been issued.
//   Characters come out most significant first on out_character, one per cycle,
//   each marked by a single-cycle out_valid. out_is_last flags the final one and
//   out_char_count then gives the length (1..11); it is zero on other beats.
// Conversion
//   Digits are produced least significant first by one shared divide unit,
//   each through the ISSUE and CAPTURE states (multiply by the reciprocal of
//   ten, then correct; hex is a shift). All digits are stored before the
//   sign or the first digit is sent.
// Reset
//   Synchronous active-low reset returns the sequencer to idle and drops
//   out_valid. Nothing is kept between numbers.
// Back-pressure
//   None: the receiver must take every beat in the cycle it is shown.
module integer_to_ascii_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [i2a_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  output logic [i2a_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_is_last,
  output logic [i2a_pkg::COUNT_W-1:0]   out_char_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CAPTURE,
    ST_EMIT
  } state_t;

  state_t                            state_r;
  logic [i2a_pkg::VALUE_W-1:0]       mag_r;
  logic                              hex_r;
  logic                              upper_r;
  logic                              sign_r;     // minus still to be sent
  logic                              neg_r;      // number is negative
  logic [i2a_pkg::NDIG_W-1:0]        nd_r;       // digits held in the store
  logic [i2a_pkg::COUNT_W-1:0]       total_r;
  logic [i2a_pkg::DIGIT_W-1:0]       digits_r [i2a_pkg::MAX_DIGITS];

  logic                              out_valid_r;
  logic [i2a_pkg::CHAR_W-1:0]        out_character_r;
  logic                              out_is_last_r;
  logic [i2a_pkg::COUNT_W-1:0]       out_char_count_r;

  logic                              accept;
  logic                              in_neg;
  logic                              unit_go;
  i2a_pkg::div_res_t                 unit_res;
  logic [i2a_pkg::NDIG_W-1:0]        nd_inc;
  logic [i2a_pkg::NDIG_W-1:0]        nd_dec;
  logic                              last_digit;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign in_neg  = (in_command == i2a_pkg::CMD_SDEC) && in_value[i2a_pkg::VALUE_W-1];
  assign unit_go = (state_r == ST_ISSUE);
  assign nd_inc  = nd_r + 1'b1;
  assign nd_dec  = nd_r - 1'b1;
  // final character: no sign pending and one digit left
  assign last_digit = !sign_r && (nd_r == i2a_pkg::NDIG_W'(1));

  i2a_digit_unit u_digit (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (unit_go),
    .hex   (hex_r),
    .mag   (mag_r),
    .res   (unit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            // magnitude taken here; two's complement negate covers the most negative value
            mag_r   <= in_neg ? (~in_value + 1'b1) : in_value;
            hex_r   <= in_command[1];
            upper_r <= (in_command == i2a_pkg::CMD_HEXUP);
            sign_r  <= in_neg;
            neg_r   <= in_neg;
            nd_r    <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_CAPTURE;
        end
        ST_CAPTURE: begin
          if (unit_res.vld) begin
            digits_r[nd_r[i2a_pkg::DIDX_W-1:0]] <= unit_res.rem;
            nd_r  <= nd_inc;
            mag_r <= unit_res.quo;
            if ((unit_res.quo == '0) || (nd_inc == i2a_pkg::NDIG_W'(i2a_pkg::MAX_DIGITS))) begin
              total_r <= i2a_pkg::COUNT_W'(nd_inc) + i2a_pkg::COUNT_W'(neg_r);
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_EMIT: begin
          out_valid_r <= 1'b1;
          if (sign_r) begin
            out_character_r  <= i2a_pkg::CHAR_MINUS;
            out_is_last_r    <= 1'b0;
            out_char_count_r <= '0;
            sign_r           <= 1'b0;
          end else begin
            out_character_r  <= i2a_pkg::digit_char(digits_r[nd_dec[i2a_pkg::DIDX_W-1:0]],
                                                    upper_r);
            out_is_last_r    <= last_digit;
            out_char_count_r <= last_digit ? total_r : '0;
            nd_r             <= nd_dec;
            if (last_digit) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_character_r;
  assign out_is_last    = out_is_last_r;
  assign out_char_count = out_char_count_r;

endmodule

// ===== tb/i2a_checker.sv =====
// Checker for the number formatter: predicts the characters of each number and compares beats.
`timescale 1ns / 100ps

module i2a_checker
  import i2a_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_command,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                out_valid,
  input  logic [CHAR_W-1:0]   out_character,
  input  logic                out_is_last,
  input  logic [COUNT_W-1:0]  out_char_count,
  output int                  fail_count,
  output int                  pending_beats,
  output int                  chars_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int         errors  = 0;
  int         checked = 0;

  // Queue up the text of one number, most significant character first
  function automatic void queue_text(input cmd_t cmd, input logic [VALUE_W-1:0] v);
    string             lower_set;
    string             upper_set;
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0] digits [10];
    logic [CHAR_W-1:0] text [11];
    logic              neg;
    int                nd;
    int                len;
    int                d;
    char_beat_t        beat;
    lower_set = "0123456789abcdef";
    upper_set = "0123456789ABCDEF";
    neg = (cmd == CMD_SDEC) && v[VALUE_W-1];
    mag = neg ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      if (cmd == CMD_HEXLO || cmd == CMD_HEXUP) begin
        d   = int'(mag[3:0]);
        mag = mag >> 4;
      end else begin
        d   = int'(mag % 10);
        mag = mag / 10;
      end
      digits[nd] = (cmd == CMD_HEXUP) ? upper_set[d] : lower_set[d];
      nd++;
    end while (mag != 0 && nd < 10);
    len = 0;
    if (neg) begin
      text[len] = "-";
      len++;
    end
    for (int k = nd - 1; k >= 0; k--) begin
      text[len] = digits[k];
      len++;
    end
    for (int k = 0; k < len; k++) begin
      beat.ch    = text[k];
      beat.last  = (k == len - 1);
      beat.count = beat.last ? COUNT_W'(len) : '0;
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat 0x%02h", out_character);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          checked++;
          if (out_character !== want.ch) begin
            $error("out_character: expected 0x%02h, got 0x%02h", want.ch, out_character);
            errors++;
          end
          if (out_is_last !== want.last) begin
            $error("out_is_last: expected %0b, got %0b", want.last, out_is_last);
            errors++;
          end
          if (out_char_count !== want.count) begin
            $error("out_char_count: expected %0d, got %0d", want.count, out_char_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        queue_text(cmd_t'(in_command), in_value);
      end
    end
    fail_count    <= errors;
    chars_checked <= checked;
    pending_beats <= expected_chars.size();
  end

endmodule

// ===== tb/tb_integer_to_ascii_formatter.sv =====
// Top of the number formatter testbench: stimulus, reset, watchdog and verdict.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;
  import i2a_pkg::*;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [1:0]          in_command     = 2'd0;
  logic [VALUE_W-1:0]  in_value       = '0;
  logic                busy;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_character;
  logic                out_is_last;
  logic [COUNT_W-1:0]  out_char_count;

  int fail_count;
  int pending_beats;
  int chars_checked;

  // Numbers taken per format, for the closing summary
  int numbers_sent [4] = '{0, 0, 0, 0};

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_to_ascii_formatter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

  i2a_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count),
    .fail_count     (fail_count),
    .pending_beats  (pending_beats),
    .chars_checked  (chars_checked)
  );

  // Offer one number and hold it until the block takes the beat. start is left
  // high on return, so a following call keeps it up without a glitch.
  task automatic send_number(input cmd_t cmd, input logic [VALUE_W-1:0] v);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= v;
    do @(posedge clk); while (busy !== 1'b0);
    numbers_sent[int'(cmd)]++;
  endtask

  // Sender gap; the data lines carry junk meanwhile, which must be ignored
  task automatic idle_for(input int cycles);
    start      <= 1'b0;
    in_command <= 2'($urandom);
    in_value   <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted character has been seen. The first edge
  // lets the checker's count catch up with a beat taken this step.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  // Values biased towards digit-count boundaries, since those decide the text length
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    int                 k;
    p = 1;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return VALUE_W'($urandom_range(0, 40));
      4, 5: begin
        // 10^k - 1, 10^k or 10^k + 1
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return p + VALUE_W'($urandom_range(0, 2)) - 1'b1;
      end
      6: begin
        // 16^k - 1, 16^k or 16^k + 1
        k = $urandom_range(0, 7);
        p = p << (4 * k);
        return p + VALUE_W'($urandom_range(0, 2)) - 1'b1;
      end
      7:       return ~VALUE_W'($urandom_range(0, 40)) + 1'b1;
      8:       return 32'h8000_0000 + VALUE_W'($urandom_range(0, 3)) - 1'b1;
      default: return VALUE_W'(1) << $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    cmd_t               cmd;
    logic [VALUE_W-1:0] edge_values [5];
    int                 idle_odds;

    edge_values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF};

    // Synchronous reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, one, all ones, the most negative value and the largest
    // positive one in every format, then a few length boundaries
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 5; j++) begin
        send_number(cmd_t'(c), edge_values[j]);
      end
    end
    send_number(CMD_UDEC, 32'd999_999_999);
    send_number(CMD_UDEC, 32'd1_000_000_000);
    send_number(CMD_HEXLO, 32'hABCD_EF01);
    send_number(CMD_HEXUP, 32'h00FE_DCBA);
    send_number(CMD_SDEC, 32'hFFFF_FFF6);   // -10
    wait_drained();

    // Random: the idle rate changes every 40 beats, no idling in the tail
    idle_odds = 0;
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) idle_odds = $urandom_range(0, 2);
      if (i == 200) wait_drained();
      if (i < 320 && idle_odds != 0 && $urandom_range(0, 3) < idle_odds) begin
        idle_for($urandom_range(1, 18));
      end
      cmd = cmd_t'($urandom_range(0, 3));
      send_number(cmd, pick_value());
    end

    // Drain, then allow for a stray beat after the last expected one
    wait_drained();
    repeat (64) @(posedge clk);

    $display("Formatted %0d signed, %0d unsigned, %0d lower hex and %0d upper hex numbers;",
             numbers_sent[0], numbers_sent[1], numbers_sent[2], numbers_sent[3]);
    $display("%0d characters compared, with gaps and back-to-back starts.", chars_checked);
    if (fail_count == 0) begin
      $display("integer_to_ascii_formatter regression: pass");
    end else begin
      $display("integer_to_ascii_formatter regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5ms;
    $display("integer_to_ascii_formatter regression: fail");
    $finish;
  end

endmodule

// ===== integer_to_ascii_formatter.f =====
rtl/i2a_pkg.sv
rtl/i2a_digit_unit.sv
rtl/integer_to_ascii_formatter.sv
tb/i2a_checker.sv
tb/tb_integer_to_ascii_formatter.sv
